FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDS_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pds assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PDS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pds assertion failed");

`endif

FILE: rtl/pds_pkg.sv
package pds_pkg;

    localparam int KIND_W     = 2;
    localparam int DB_W       = 4;
    localparam int MARGIN_W   = 6;
    localparam int LEVEL_W    = 7;
    localparam int LIVE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int WIN_DEPTH  = 3;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_kind KIND_SAMPLE    = 2'd0;
    localparam t_kind KIND_CAL_START = 2'd1;
    localparam t_kind KIND_CAL_STOP  = 2'd2;
    localparam t_kind KIND_LINEAR    = 2'd3;

    localparam t_cfg_idx CFG_IDX_DEADBAND = 1'd0;
    localparam t_cfg_idx CFG_IDX_MARGIN   = 1'd1;

    localparam logic [DB_W-1:0]     DEADBAND_RESET = 4'd2;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 6'd4;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 7'd127;

    typedef struct packed {
        logic [DB_W-1:0]     deadband;
        logic [MARGIN_W-1:0] edge_margin;
    } t_cfg;

    typedef struct packed {
        logic               report_valid;
        logic [LEVEL_W-1:0] pedal_level;
        logic               live_valid;
        logic [LIVE_W-1:0]  live_value;
    } t_result;

endpackage

FILE: rtl/pds_div.sv
module pds_div #(
    parameter int DIVIDEND_W = 15,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] trial_sub;
    logic               fits;

    assign trial     = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, r_div};
    assign trial_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pds_front.sv
module pds_front #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  pds_pkg::t_kind         i_kind,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output pds_pkg::t_kind         o_q_kind,
    output logic [SAMPLE_BITS-1:0] o_q_sample
);

    import pds_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_kind                  r_kind   [QDEPTH];
    logic [SAMPLE_BITS-1:0] r_sample [QDEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    logic                   push;
    logic                   pop;
    logic [SAMPLE_BITS-1:0] n_sample;

    assign o_ready   = r_count != CNT_W'(QDEPTH);
    assign o_q_valid = r_count != '0;
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    // drop the payload of control words
    assign n_sample = (i_kind == KIND_SAMPLE) ? i_sample : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wr_ptr]   <= i_kind;
            r_sample[r_wr_ptr] <= n_sample;
        end
    end

    assign o_q_kind   = r_kind[r_rd_ptr];
    assign o_q_sample = r_sample[r_rd_ptr];

endmodule

FILE: rtl/pds_back.sv
module pds_back #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pds_pkg::t_cfg          i_cfg,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  pds_pkg::t_kind         i_q_kind,
    input  logic [SAMPLE_BITS-1:0] i_q_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output pds_pkg::t_result       o_result
);

    import pds_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int DW      = SAMPLE_BITS + LEVEL_W;
    localparam int SUM_W   = SAMPLE_BITS + 2;
    localparam int RECIP_K = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_K;

    localparam logic [RECIP_K-1:0] RECIP_DEPTH =
        RECIP_K'(((1 << RECIP_K) + WIN_DEPTH - 1) / WIN_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AVG   = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    r_state,   n_state;
    logic [SB-1:0] r_win [WIN_DEPTH];
    logic [SB-1:0] n_win [WIN_DEPTH];
    logic [1:0]    r_phase,   n_phase;
    logic [SB-1:0] r_avg,     n_avg;
    logic          r_cal,     n_cal;
    logic [SB-1:0] r_bnd_lo,  n_bnd_lo;
    logic [SB-1:0] r_bnd_hi,  n_bnd_hi;
    logic [SB-1:0] r_cap_lo,  n_cap_lo;
    logic [SB-1:0] r_cap_hi,  n_cap_hi;
    logic          r_cap_seen, n_cap_seen;
    logic          r_out_valid, n_out_valid;
    logic [SB-1:0] r_sample,  n_sample;
    t_result       r_res,     n_res;
    t_result       r_out,     n_out;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [SB-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quotient;

    logic [SUM_W-1:0]   sum3;
    logic [PROD_W-1:0]  avg_prod;
    logic [1:0]         phase_inc;
    logic [SB:0]        s_ext;
    logic [SB:0]        avg_ext;
    logic [SB:0]        db_ext;
    logic [SB:0]        margin_ext;
    logic               outside;
    logic [SB:0]        lo_trim;
    logic [SB:0]        lo_twice;
    logic [SB:0]        span_raw;
    logic               span_ok;
    logic [SB-1:0]      span;
    logic               diff_ok;
    logic [SB:0]        diff_raw;
    logic [DW-1:0]      diff_ext;
    logic [DW-1:0]      scale_dividend;
    logic [LEVEL_W-1:0] level_v;
    logic [LEVEL_W-1:0] level;
    t_result            res_zero;
    t_result            res_report;

    assign sum3      = SUM_W'(r_win[0]) + SUM_W'(r_win[1]) + SUM_W'(r_win[2]);
    assign avg_prod  = PROD_W'(sum3) * PROD_W'(RECIP_DEPTH);
    assign phase_inc = r_phase + 2'd1;

    assign s_ext      = {1'b0, r_sample};
    assign avg_ext    = {1'b0, r_avg};
    assign db_ext     = (SB+1)'(i_cfg.deadband);
    assign margin_ext = (SB+1)'(i_cfg.edge_margin);
    assign outside    = (s_ext > avg_ext + db_ext) || (s_ext + db_ext < avg_ext);

    assign lo_trim  = {1'b0, r_bnd_lo} + margin_ext;
    assign lo_twice = lo_trim + margin_ext;
    assign span_ok  = {1'b0, r_bnd_hi} > lo_twice;
    assign span_raw = {1'b0, r_bnd_hi} - lo_twice;
    assign span     = span_ok ? span_raw[SB-1:0] : SB'(1);
    assign diff_ok  = s_ext > lo_trim;
    assign diff_raw = s_ext - lo_trim;
    assign diff_ext = DW'(diff_raw[SB-1:0]);
    assign scale_dividend = (diff_ext << LEVEL_W) - diff_ext;

    assign level_v = (|div_quotient[DW-1:LEVEL_W]) ? LEVEL_MAX : div_quotient[LEVEL_W-1:0];
    assign level   = LEVEL_MAX - level_v;

    assign res_zero = '0;

    always_comb begin
        res_report              = '0;
        res_report.report_valid = 1'b1;
        res_report.live_valid   = 1'b1;
        res_report.pedal_level  = level;
        res_report.live_value   = LIVE_W'(level);
    end

    assign div_start    = (r_state == ST_CMP) && outside && diff_ok;
    assign div_dividend = scale_dividend;
    assign div_divisor  = span;

    pds_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign o_q_ready = r_state == ST_IDLE;

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_phase     = r_phase;
        n_avg       = r_avg;
        n_cal       = r_cal;
        n_bnd_lo    = r_bnd_lo;
        n_bnd_hi    = r_bnd_hi;
        n_cap_lo    = r_cap_lo;
        n_cap_hi    = r_cap_hi;
        n_cap_seen  = r_cap_seen;
        n_sample    = r_sample;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_sample = i_q_sample;
                    n_res    = res_zero;
                    n_state  = ST_DONE;
                    case (i_q_kind)
                        KIND_SAMPLE: begin
                            if (r_cal) begin
                                if (!r_cap_seen) begin
                                    n_cap_lo   = i_q_sample;
                                    n_cap_hi   = i_q_sample;
                                    n_cap_seen = 1'b1;
                                end else begin
                                    if (i_q_sample < r_cap_lo) begin
                                        n_cap_lo = i_q_sample;
                                    end
                                    if (i_q_sample > r_cap_hi) begin
                                        n_cap_hi = i_q_sample;
                                    end
                                end
                                n_res.live_valid = 1'b1;
                                n_res.live_value = i_q_sample[LIVE_W-1:0];
                            end else begin
                                n_win[0] = i_q_sample;
                                n_win[1] = r_win[0];
                                n_win[2] = r_win[1];
                                if (phase_inc == 2'(WIN_DEPTH)) begin
                                    n_phase = 2'd0;
                                    n_state = ST_AVG;
                                end else begin
                                    n_phase = phase_inc;
                                    n_state = ST_CMP;
                                end
                            end
                        end
                        KIND_CAL_START: begin
                            n_cal      = 1'b1;
                            n_cap_seen = 1'b0;
                        end
                        KIND_CAL_STOP: begin
                            if (r_cap_seen) begin
                                n_bnd_lo = r_cap_lo;
                                n_bnd_hi = r_cap_hi;
                            end
                            n_cal = 1'b0;
                        end
                        KIND_LINEAR: begin
                            n_bnd_lo   = '0;
                            n_bnd_hi   = SB'(LEVEL_MAX);
                            n_cap_lo   = '0;
                            n_cap_hi   = SB'(LEVEL_MAX);
                            n_cap_seen = 1'b1;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_AVG: begin
                n_avg   = avg_prod[RECIP_K +: SB];
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!outside) begin
                    n_state = ST_DONE;
                end else if (!diff_ok) begin
                    n_res                  = res_zero;
                    n_res.report_valid     = 1'b1;
                    n_res.live_valid       = 1'b1;
                    n_res.pedal_level      = LEVEL_MAX;
                    n_res.live_value       = LIVE_W'(LEVEL_MAX);
                    n_state                = ST_DONE;
                end else begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    n_res   = res_report;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win[0]    <= '0;
            r_win[1]    <= '0;
            r_win[2]    <= '0;
            r_phase     <= '0;
            r_avg       <= '0;
            r_cal       <= 1'b0;
            r_bnd_lo    <= '0;
            r_bnd_hi    <= SB'(LEVEL_MAX);
            r_cap_lo    <= '0;
            r_cap_hi    <= '0;
            r_cap_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win       <= n_win;
            r_phase     <= n_phase;
            r_avg       <= n_avg;
            r_cal       <= n_cal;
            r_bnd_lo    <= n_bnd_lo;
            r_bnd_hi    <= n_bnd_hi;
            r_cap_lo    <= n_cap_lo;
            r_cap_hi    <= n_cap_hi;
            r_cap_seen  <= n_cap_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/pedal_deadband_scaler_core.sv
// channel  direction  handshake            payload
// input    in         i_valid / o_ready    i_kind, i_sample
// result   out        o_valid / i_ready    o_report_valid, o_pedal_level,
//                                          o_live_valid, o_live_value
// config   in         i_cfg_wr_en          i_cfg_index, i_cfg_wdata
//
// Control words and calibration samples pass from the queue through ST_DONE to the
// result register. A sample that refreshes the average also passes ST_AVG for the
// reciprocal multiply; a reported sample waits in ST_SCALE on the serial divider,
// which sets the worst case.
// Reset is synchronous, active low; no clearing pass is needed.
// A two-word queue lets input words be taken while a result waits on i_ready.
module pedal_deadband_scaler_core #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pds_pkg::t_kind                  i_kind,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_report_valid,
    output logic [pds_pkg::LEVEL_W-1:0]     o_pedal_level,
    output logic                            o_live_valid,
    output logic [pds_pkg::LIVE_W-1:0]      o_live_value,
    input  logic                            i_cfg_wr_en,
    input  pds_pkg::t_cfg_idx               i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    import pds_pkg::*;

    t_cfg                   r_cfg;
    logic                   q_valid;
    logic                   q_ready;
    t_kind                  q_kind;
    logic [SAMPLE_BITS-1:0] q_sample;
    t_result                result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband    <= DEADBAND_RESET;
            r_cfg.edge_margin <= MARGIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDX_DEADBAND: r_cfg.deadband    <= i_cfg_wdata[DB_W-1:0];
                CFG_IDX_MARGIN:   r_cfg.edge_margin <= i_cfg_wdata[MARGIN_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pds_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_kind     (i_kind),
        .i_sample   (i_sample),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_kind   (q_kind),
        .o_q_sample (q_sample)
    );

    pds_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_kind   (q_kind),
        .i_q_sample (q_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_report_valid = result.report_valid;
    assign o_pedal_level  = result.pedal_level;
    assign o_live_valid   = result.live_valid;
    assign o_live_value   = result.live_value;

endmodule

FILE: rtl/pds_checker.sv
`include "assert_macros.svh"

module pds_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_report_valid,
    input logic [pds_pkg::LEVEL_W-1:0] o_pedal_level,
    input logic                        o_live_valid,
    input logic [pds_pkg::LIVE_W-1:0]  o_live_value
);

    import pds_pkg::*;

    `PDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PDS_ASSERT_IMPLY(a_level_zero, i_clk, i_rst_n, o_valid && !o_report_valid, o_pedal_level == '0)
    `PDS_ASSERT_IMPLY(a_report_live, i_clk, i_rst_n, o_valid && o_report_valid, o_live_valid && o_live_value == LIVE_W'(o_pedal_level))
    `PDS_ASSERT_IMPLY(a_live_zero, i_clk, i_rst_n, o_valid && !o_live_valid, o_live_value == '0 && !o_report_valid)

endmodule

bind pedal_deadband_scaler_core pds_checker u_pds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_report_valid (o_report_valid),
    .o_pedal_level  (o_pedal_level),
    .o_live_valid   (o_live_valid),
    .o_live_value   (o_live_value)
);
